[rtl/lkv_pkg.sv]
// Shared types and constants for the LRU key-value cache.
package lkv_pkg;

    // Storage geometry
    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 64;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Fixed field widths
    localparam int KEY_W    = 31;
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 7;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Register map (byte address bit 2 selects the register word)
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic {
        CMD_PUT = 1'b0,
        CMD_GET = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND   = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_NOCACHE = 2'd2
    } t_status;

    // Request and response payloads
    typedef struct packed {
        logic              cmd;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data_in;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data_out;
    } t_rsp;

    // One entry of the recency-ordered row
    typedef struct packed {
        logic                  valid;
        logic [KEY_W-1:0]      key;
        logic [VALUE_BITS-1:0] value;
    } t_entry;

    // Per-cell control from the row controller
    typedef struct packed {
        logic clear;     // drop the entry
        logic shift;     // take the neighbor's entry
        logic in_range;  // position lies below the capacity
    } t_cell_ctrl;

endpackage

[rtl/lkv_cell.sv]
// One position of the recency-ordered entry row: holds an entry and compares its key.
module lkv_cell import lkv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctrl       i_ctrl,
    input  t_entry           i_prev,
    input  logic [KEY_W-1:0] i_key,
    output t_entry           o_entry,
    output logic             o_match
);

    logic                  r_valid;
    logic [KEY_W-1:0]      r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  n_valid;

    // Valid bit: cleared by config, otherwise follows the neighbor on a shift
    always_comb begin
        n_valid = r_valid;
        if (i_ctrl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctrl.shift) begin
            n_valid = i_prev.valid && i_ctrl.in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload moves with the shift, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_key   <= i_prev.key;
            r_value <= i_prev.value;
        end
    end

    assign o_entry.valid = r_valid;
    assign o_entry.key   = r_key;
    assign o_entry.value = r_value;
    assign o_match       = r_valid && (r_key == i_key);

endmodule

[rtl/lru_key_value_cache.sv]
// Top level of the LRU key-value cache: request handling, config port and the cell row.
// Entries sit in a row of cells ordered by recency, most recent in cell 0. In the accept
// cycle every cell compares its key with the request key in parallel and the match vector
// is registered; once the output register is free or being read, the row shifts once (a hit
// moves to the front, a put miss pushes a new entry in and drops the least recent one when
// the row is full) and the response is loaded into the output register. A new request is
// taken once that shift is done, so the block does not take a new request while the last
// one is in flight; a response that is not taken holds back the shift of the following one.
// Writing the capacity register empties the cache; no clearing pass follows reset.
module lru_key_value_cache import lkv_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_req               i_in_data,
    // Response channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_rsp               o_out_data,
    // Config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [CNT_W-1:0]      r_capacity;
    logic                  r_busy;
    t_req                  r_req;
    logic [CAPACITY-1:0]   r_match;
    logic                  r_out_valid;
    t_rsp                  r_out;

    logic                  cfg_wr;
    logic [CFG_W-1:0]      cfg_val;
    logic                  accept;
    logic                  fire;
    logic                  key_zero;
    logic                  cap_zero;
    logic                  hit;
    logic                  do_update;
    logic [CAPACITY-1:0]   match_now;
    logic [CAPACITY-1:0]   at_or_after;
    logic [VALUE_BITS-1:0] hit_value;
    t_entry                front;
    t_rsp                  n_out;
    t_entry                cell_entry [CAPACITY];
    t_cell_ctrl            cell_ctrl  [CAPACITY];

    // Config write handshake
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
    assign cfg_val = pwdata[CFG_W-1:0];
    assign prdata  = PDATA_W'(r_capacity);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
        end else if (cfg_wr) begin
            r_capacity <= (int'(cfg_val) > CAPACITY) ? CNT_W'(CAPACITY) : CNT_W'(cfg_val);
        end
    end

    // Request acceptance and row update timing
    assign o_in_ready = !r_busy;
    assign accept     = i_in_valid && o_in_ready;
    assign fire       = r_busy && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
        end else if (fire) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req   <= i_in_data;
            r_match <= match_now;
        end
    end

    // Decode of the registered compare
    assign key_zero = (r_req.key == '0);
    assign cap_zero = (r_capacity == '0);
    assign hit      = |r_match;

    // Cells up to and including the hit position (log-step prefix OR)
    always_comb begin
        at_or_after = r_match;
        for (int s = 1; s < CAPACITY; s = s * 2) begin
            at_or_after = at_or_after | (at_or_after >> s);
        end
    end

    // Value of the matching entry (at most one cell matches)
    always_comb begin
        hit_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (r_match[i]) begin
                hit_value = hit_value | cell_entry[i].value;
            end
        end
    end

    assign do_update = fire && !key_zero && !cap_zero && (hit || (r_req.cmd == CMD_PUT));

    // New front entry
    always_comb begin
        front.valid = 1'b1;
        front.key   = r_req.key;
        front.value = (r_req.cmd == CMD_PUT) ? r_req.data_in[VALUE_BITS-1:0] : hit_value;
    end

    // Per-cell control: a hit shifts only the cells up to its position
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_ctrl[i].clear    = cfg_wr;
            cell_ctrl[i].shift    = do_update && (!hit || at_or_after[i]);
            cell_ctrl[i].in_range = (CNT_W'(i) < r_capacity);
        end
    end

    // Cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        lkv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (cell_ctrl[g]),
            .i_prev  ((g == 0) ? front : cell_entry[(g == 0) ? 0 : g - 1]),
            .i_key   (i_in_data.key),
            .o_entry (cell_entry[g]),
            .o_match (match_now[g])
        );
    end

    // Response
    always_comb begin
        n_out.data_out = '0;
        if (key_zero) begin
            n_out.status = ST_ABSENT;
        end else if (cap_zero) begin
            n_out.status = ST_NOCACHE;
        end else if (hit) begin
            n_out.status = ST_FOUND;
            if (r_req.cmd == CMD_GET) begin
                n_out.data_out = DATA_W'(hit_value);
            end
        end else begin
            n_out.status = ST_ABSENT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
